### hdl/kct_pkg.sv
`timescale 1ns / 1ps

package kct_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned COUNT_W = 31;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_SET  = 2'd2,
    CMD_DUMP = 2'd3
  } cmd_e;

  localparam logic [2:0] STATUS_OK     = 3'd0;
  localparam logic [2:0] STATUS_NEG    = 3'd1;
  localparam logic [2:0] STATUS_FULL   = 3'd2;
  localparam logic [2:0] STATUS_ABSENT = 3'd3;
  localparam logic [2:0] STATUS_EMPTY  = 3'd4;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] key;
    logic signed [31:0] count_value;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0]   out_key;
    logic [2:0]         status;
    logic               last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic dump_step;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic is_dump;
    logic table_empty;
    logic dump_last;
  } dp_status_t;

endpackage

### hdl/kct_ctrl.sv
`timescale 1ns / 1ps

module kct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kct_pkg::dp_status_t sts_i,
  output kct_pkg::ctrl_cmd_t  cmd_o
);
  import kct_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DUMP = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = (sts_i.is_dump && !sts_i.table_empty) ? ST_DUMP : ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.dump_step = 1'b1;
          if (sts_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/kct_dpath.sv
`timescale 1ns / 1ps

module kct_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kct_pkg::in_item_t   in_item_i,
  input  kct_pkg::ctrl_cmd_t  cmd_i,
  output kct_pkg::dp_status_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kct_pkg::out_item_t  out_item_o
);
  import kct_pkg::*;

  logic [KEY_W-1:0]   key_store_q   [ENTRIES];
  logic [COUNT_W-1:0] count_store_q [ENTRIES];
  logic [CNT_W-1:0]   used_q;

  cmd_e               op_q;
  logic [31:0]        key_q;
  logic [31:0]        val_q;
  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;

  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, res;
  logic               out_ld;

  logic               key_we, cnt_we, used_inc;
  logic [IDX_W-1:0]   cnt_widx;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] cur_count;
  logic [IDX_W-1:0]   free_idx;
  logic               full;
  logic               err;
  logic [KEY_W-1:0]   k;
  logic [COUNT_W-1:0] v;

  assign free_idx  = used_q[IDX_W-1:0];
  assign full      = (used_q == CNT_W'(ENTRIES));
  assign cur_count = count_store_q[slot_q];
  assign k         = key_q[KEY_W-1:0];
  assign v         = val_q[COUNT_W-1:0];
  assign err       = key_q[31] || ((op_q == CMD_SET) && val_q[31]);

  // parallel key match against every filled slot
  always_comb begin
    hit_d  = 1'b0;
    slot_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < used_q) && (key_store_q[i] == in_item_i.key[KEY_W-1:0])) begin
        hit_d  = 1'b1;
        slot_d = IDX_W'(i);
      end
    end
  end

  assign ptr_d = (cmd_i.load) ? IDX_W'(used_q - CNT_W'(1)) : IDX_W'(ptr_q - IDX_W'(1));

  // execute one add, get, set or empty dump, or one step of a dump walk
  always_comb begin
    res       = '0;
    res.last  = 1'b1;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    used_inc  = 1'b0;
    cnt_widx  = slot_q;
    cnt_wdata = v;
    out_ld    = 1'b0;
    if (cmd_i.exec) begin
      out_ld = 1'b1;
      if (op_q == CMD_DUMP) begin
        res.status = STATUS_EMPTY;
        out_ld     = (used_q == '0);
      end else if (err) begin
        res.status = STATUS_NEG;
      end else if (op_q == CMD_GET) begin
        res.out_key = k;
        res.status  = hit_q ? STATUS_OK : STATUS_ABSENT;
        res.count   = hit_q ? cur_count : '0;
      end else if (hit_q) begin
        cnt_we      = 1'b1;
        if (op_q == CMD_ADD) begin
          cnt_wdata = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
        end
        res.out_key = k;
        res.count   = cnt_wdata;
      end else if (full) begin
        res.out_key = k;
        res.status  = STATUS_FULL;
      end else begin
        key_we      = 1'b1;
        cnt_we      = 1'b1;
        used_inc    = 1'b1;
        cnt_widx    = free_idx;
        if (op_q == CMD_ADD) begin
          cnt_wdata = COUNT_W'(1);
        end
        res.out_key = k;
        res.count   = cnt_wdata;
      end
    end else if (cmd_i.dump_step) begin
      out_ld      = 1'b1;
      res.count   = count_store_q[ptr_q];
      res.out_key = key_store_q[ptr_q];
      res.last    = (ptr_q == '0);
    end
  end

  assign out_valid_d = out_ld || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_item_i.cmd;
      key_q  <= in_item_i.key;
      val_q  <= in_item_i.count_value;
      hit_q  <= hit_d;
      slot_q <= slot_d;
    end
    if (cmd_i.load || cmd_i.dump_step) begin
      ptr_q <= ptr_d;
    end
    if (key_we) begin
      key_store_q[free_idx] <= k;
    end
    if (cnt_we) begin
      count_store_q[cnt_widx] <= cnt_wdata;
    end
    if (out_ld) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (used_inc) begin
        used_q <= used_q + CNT_W'(1);
      end
    end
  end

  assign sts_o.out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.is_dump     = (op_q == CMD_DUMP);
  assign sts_o.table_empty = (used_q == '0);
  assign sts_o.dump_last   = (ptr_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### hdl/key_count_table_top.sv
`timescale 1ns / 1ps
// The item and its key match are registered on acceptance; add, get and set then load
// their result into the output register in the execute state once that register is free.
// No new item is taken until the current one is done; a dump emits its N pairs newest first.
// The output register lets a result wait while the next item is accepted.
// Reset clears the fill count, the controller and the output valid; stores are not cleared.

module key_count_table_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kct_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kct_pkg::out_item_t out_item_o
);
  import kct_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequence each item: capture and match, then execute or walk the dump.
  kct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the key and count slots, the fill count and the output register.
  kct_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kct_pkg::*;

  localparam logic [31:0] K_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam int          RAND_ITEMS = 400;
  localparam int          HOLD_LEN   = 300;   // one long receiver hold-off
  localparam int          HOLD_AFTER = 100;   // results seen before the hold-off starts
  localparam int          IDLE_LIMIT = 3000;  // cycles with no item moving on either side
  localparam int          TAIL_WAIT  = 48;    // covers a full dump of ENTRIES pairs

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  key_count_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Shadow copy of the table: slots fill in insertion order and are never freed.
  logic [KEY_W-1:0]   shadow_keys   [ENTRIES];
  logic [COUNT_W-1:0] shadow_counts [ENTRIES];
  int                 shadow_used;

  out_item_t replies_due[$];   // results owed by the block, oldest first
  out_item_t oldest_reply;
  int        mismatches   = 0;
  int        results_seen = 0;
  int        idle_cycles  = 0;
  int        burst_left   = 0;

  typedef struct {
    in_item_t  item;
    bit        typed;   // expectation written by hand in the table
    out_item_t reply;
  } probe_row_t;

  probe_row_t probe_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_item_t result_of(input logic [COUNT_W-1:0] c,
                                          input logic [KEY_W-1:0] k,
                                          input logic [2:0] s, input logic l);
    out_item_t r;
    r.count   = c;
    r.out_key = k;
    r.status  = s;
    r.last    = l;
    return r;
  endfunction

  // Work out the replies for one accepted item and update the shadow table.
  function automatic void apply_command(input in_item_t it);
    logic [KEY_W-1:0]   k;
    logic [COUNT_W-1:0] v;
    int                 hit;
    k   = it.key[KEY_W-1:0];
    v   = it.count_value[COUNT_W-1:0];
    hit = -1;
    if (it.cmd == CMD_DUMP) begin
      // Emit newest slot first; flag the oldest as the final reply.
      if (shadow_used == 0)
        replies_due.push_back(result_of('0, '0, STATUS_EMPTY, 1'b1));
      for (int i = shadow_used - 1; i >= 0; i--)
        replies_due.push_back(result_of(shadow_counts[i], shadow_keys[i], STATUS_OK, i == 0));
      return;
    end
    // Drop negative keys, and negative counts on set, without touching the table.
    if (it.key[31] || (it.cmd == CMD_SET && it.count_value[31])) begin
      replies_due.push_back(result_of('0, '0, STATUS_NEG, 1'b1));
      return;
    end
    for (int i = 0; i < shadow_used; i++)
      if (hit < 0 && shadow_keys[i] == k) hit = i;
    if (it.cmd == CMD_GET) begin
      if (hit < 0) replies_due.push_back(result_of('0, k, STATUS_ABSENT, 1'b1));
      else         replies_due.push_back(result_of(shadow_counts[hit], k, STATUS_OK, 1'b1));
    end else if (hit >= 0) begin
      // Saturate add at the top count; set overwrites.
      if (it.cmd == CMD_SET)                  shadow_counts[hit] = v;
      else if (shadow_counts[hit] != COUNT_MAX) shadow_counts[hit] = shadow_counts[hit] + 1'b1;
      replies_due.push_back(result_of(shadow_counts[hit], k, STATUS_OK, 1'b1));
    end else if (shadow_used >= ENTRIES) begin
      replies_due.push_back(result_of('0, k, STATUS_FULL, 1'b1));
    end else begin
      shadow_keys[shadow_used]   = k;
      shadow_counts[shadow_used] = (it.cmd == CMD_ADD) ? COUNT_W'(1) : v;
      replies_due.push_back(result_of(shadow_counts[shadow_used], k, STATUS_OK, 1'b1));
      shadow_used++;
    end
  endfunction

  function automatic void add_probe(input cmd_e c, input logic [31:0] k, input logic [31:0] v,
                                    input bit typed, input logic [COUNT_W-1:0] cnt,
                                    input logic [KEY_W-1:0] okey, input logic [2:0] st);
    probe_row_t row;
    row.item.cmd         = c;
    row.item.key         = k;
    row.item.count_value = v;
    row.typed            = typed;
    row.reply            = result_of(cnt, okey, st, 1'b1);
    probe_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
  endtask

  // Offer one item and hold it until accepted. Predict at the accepting edge.
  // Idle the input between bursts so gaps land on every phase of the block.
  task automatic drive_item(input in_item_t it, input bit typed, input out_item_t reply);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_command(it);
    if (typed) begin
      void'(replies_due.pop_back());
      replies_due.push_back(reply);
    end
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Check each result against the oldest reply owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_item_o.out_key), '0);
      end else begin
        oldest_reply = replies_due.pop_front();
        if (out_item_o.count !== oldest_reply.count)
          report_mismatch("count", 32'(out_item_o.count), 32'(oldest_reply.count));
        if (out_item_o.out_key !== oldest_reply.out_key)
          report_mismatch("out_key", 32'(out_item_o.out_key), 32'(oldest_reply.out_key));
        if (out_item_o.status !== oldest_reply.status)
          report_mismatch("status", 32'(out_item_o.status), 32'(oldest_reply.status));
        if (out_item_o.last !== oldest_reply.last)
          report_mismatch("last", 32'(out_item_o.last), 32'(oldest_reply.last));
      end
    end
  end

  // End the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: stall on segments of random mode, and hold off once for a long
  // stretch so the block fills up and stalls its input.
  initial begin
    int mode;
    int seg;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 96);
      repeat (seg) begin
        @(posedge clk_i);
        if (!hold_done && results_seen >= HOLD_AFTER) begin
          hold_done = 1'b1;
          out_stall_i <= 1'b1;
          repeat (HOLD_LEN) @(posedge clk_i);
        end
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  initial begin
    in_item_t it;
    int       pick;
    shadow_used = 0;

    // Hand-checked probes first: empty dump, negatives, absent get,
    // extremes of key and count, saturation, ignored fields.
    add_probe(CMD_DUMP, 32'd0,        32'd0,        1'b1, '0, '0, STATUS_EMPTY);
    add_probe(CMD_GET,  32'd5,        32'd0,        1'b1, '0, 31'd5, STATUS_ABSENT);
    add_probe(CMD_ADD,  SIGN_BIT,     32'd0,        1'b1, '0, '0, STATUS_NEG);
    add_probe(CMD_SET,  32'd7,        32'hffff_ffff, 1'b1, '0, '0, STATUS_NEG);
    add_probe(CMD_GET,  32'hffff_ffff, 32'd0,       1'b1, '0, '0, STATUS_NEG);
    add_probe(CMD_ADD,  32'd0,        32'd0,        1'b1, 31'd1, '0, STATUS_OK);
    add_probe(CMD_ADD,  32'd0,        32'd0,        1'b1, 31'd2, '0, STATUS_OK);
    add_probe(CMD_SET,  K_MAX,        K_MAX,        1'b1, COUNT_MAX, K_MAX[30:0], STATUS_OK);
    add_probe(CMD_ADD,  K_MAX,        32'd0,        1'b1, COUNT_MAX, K_MAX[30:0], STATUS_OK);
    add_probe(CMD_GET,  K_MAX,        SIGN_BIT,     1'b1, COUNT_MAX, K_MAX[30:0], STATUS_OK);
    add_probe(CMD_SET,  32'd0,        32'd0,        1'b1, '0, '0, STATUS_OK);
    add_probe(CMD_ADD,  32'd0,        32'hffff_fffb, 1'b1, 31'd1, '0, STATUS_OK);
    add_probe(CMD_SET,  32'd12345,    32'h5555_5555, 1'b1, 31'h5555_5555, 31'd12345, STATUS_OK);
    add_probe(CMD_SET,  32'h2aaa_aaaa, 32'h2aaa_aaaa, 1'b1, 31'h2aaa_aaaa, 31'h2aaa_aaaa,
              STATUS_OK);
    add_probe(CMD_SET,  32'd99,       K_MAX - 1,    1'b1, COUNT_MAX - 1'b1, 31'd99, STATUS_OK);
    add_probe(CMD_ADD,  32'd99,       32'd0,        1'b1, COUNT_MAX, 31'd99, STATUS_OK);
    add_probe(CMD_ADD,  32'd99,       32'd0,        1'b1, COUNT_MAX, 31'd99, STATUS_OK);
    add_probe(CMD_DUMP, SIGN_BIT,     32'hffff_ffff, 1'b0, '0, '0, STATUS_OK);
    add_probe(CMD_GET,  32'd0,        SIGN_BIT,     1'b1, 31'd1, '0, STATUS_OK);
    add_probe(CMD_SET,  K_MAX,        32'd0,        1'b0, '0, '0, STATUS_OK);
    add_probe(CMD_ADD,  32'h5555_5555, 32'd0,       1'b0, '0, '0, STATUS_OK);
    add_probe(CMD_DUMP, 32'd1,        32'd1,        1'b0, '0, '0, STATUS_OK);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (probe_rows[i]) drive_item(probe_rows[i].item, probe_rows[i].typed,
                                       probe_rows[i].reply);

    // Random part: keys mostly from a small pool so hits are common and the
    // table fills up; the rest exercise negatives, wide keys and the top key.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 36)      it.cmd = CMD_ADD;
      else if (pick < 62) it.cmd = CMD_GET;
      else if (pick < 94) it.cmd = CMD_SET;
      else                it.cmd = CMD_DUMP;
      pick = $urandom_range(0, 99);
      if (pick < 6)       it.key = $urandom | SIGN_BIT;
      else if (pick < 16) it.key = $urandom & K_MAX;
      else if (pick < 19) it.key = K_MAX - $urandom_range(0, 2);
      else                it.key = $urandom_range(0, 47);
      pick = $urandom_range(0, 99);
      if (pick < 8)       it.count_value = $urandom | SIGN_BIT;
      else if (pick < 20) it.count_value = K_MAX - $urandom_range(0, 2);
      else if (pick < 60) it.count_value = $urandom & K_MAX;
      else                it.count_value = $urandom_range(0, 100);
      drive_item(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (replies_due.size() != 0) report_mismatch("missing result", replies_due.size(), 0);

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
